>>> rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_IMPL(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_NEXT(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

>>> rtl/jsds_pkg.sv
// Package: widths, sizes and payload types of the job scheduler.
`default_nettype none

package jsds_pkg;

  localparam int MAX_JOBS    = 32;
  localparam int DEADLINE_W  = 16;
  localparam int PROFIT_W    = 32;
  localparam int JOB_ID_W    = 6;
  localparam int SLOT_W      = 5;
  localparam int CNT_W       = $clog2(MAX_JOBS + 1);
  localparam int IDX_W       = $clog2(MAX_JOBS);
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [DEADLINE_W-1:0]      deadline;
    logic signed [PROFIT_W-1:0] profit;
    logic                       last_job;
  } job_t;

  typedef struct packed {
    logic [JOB_ID_W-1:0] job_id;
    logic [SLOT_W-1:0]   slot_index;
    logic                last_result;
  } result_t;

  // One ranked job on its way to slot allocation; top is the clipped deadline.
  typedef struct packed {
    logic [CNT_W-1:0]    top;
    logic [JOB_ID_W-1:0] job_id;
    logic                last;
  } sched_t;

endpackage

`default_nettype wire

>>> rtl/jsds_front.sv
// Front end: insertion-sort chain that ranks jobs by profit, then drains them in rank order.
`default_nettype none

module jsds_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  jsds_pkg::job_t  job,
  output logic            busy,
  output logic            push,
  output jsds_pkg::sched_t push_entry,
  input  logic            queue_full
);
  import jsds_pkg::*;

  logic signed [PROFIT_W-1:0] profit      [MAX_JOBS];
  logic signed [PROFIT_W-1:0] profit_next [MAX_JOBS];
  logic [DEADLINE_W-1:0]      deadline      [MAX_JOBS];
  logic [DEADLINE_W-1:0]      deadline_next [MAX_JOBS];
  logic [JOB_ID_W-1:0]        id      [MAX_JOBS];
  logic [JOB_ID_W-1:0]        id_next [MAX_JOBS];

  // value of the cell above each cell, for the shift-down on insert
  logic signed [PROFIT_W-1:0] profit_up   [MAX_JOBS];
  logic [DEADLINE_W-1:0]      deadline_up [MAX_JOBS];
  logic [JOB_ID_W-1:0]        id_up       [MAX_JOBS];

  logic [CNT_W-1:0]    count, count_next;
  logic [CNT_W-1:0]    set_size, set_size_next;
  logic                draining, draining_next;
  logic                accept, room, shift;
  logic [MAX_JOBS-1:0] ge, ge_up;
  logic [JOB_ID_W-1:0] new_id;

  assign busy   = draining;
  assign accept = start && !draining;
  assign room   = count < CNT_W'(MAX_JOBS);
  assign shift  = draining && !queue_full;
  assign push   = shift;
  assign new_id = JOB_ID_W'(count + CNT_W'(1));

  always_comb begin
    for (int k = 0; k < MAX_JOBS; k++) begin
      ge[k] = profit[k] >= job.profit;
    end
    ge_up = {ge[MAX_JOBS-2:0], 1'b1};
    profit_up[0]   = profit[0];
    deadline_up[0] = deadline[0];
    id_up[0]       = id[0];
    for (int k = 1; k < MAX_JOBS; k++) begin
      profit_up[k]   = profit[k-1];
      deadline_up[k] = deadline[k-1];
      id_up[k]       = id[k-1];
    end
  end

  // head of the chain, deadline clipped to the set size
  always_comb begin
    push_entry.top    = (deadline[0] < DEADLINE_W'(set_size)) ?
                        deadline[0][CNT_W-1:0] : set_size;
    push_entry.job_id = id[0];
    push_entry.last   = count == CNT_W'(1);
  end

  always_comb begin
    profit_next   = profit;
    deadline_next = deadline;
    id_next       = id;
    count_next    = count;
    draining_next = draining;
    set_size_next = set_size;
    if (shift) begin
      for (int k = 0; k < MAX_JOBS - 1; k++) begin
        profit_next[k]   = profit[k+1];
        deadline_next[k] = deadline[k+1];
        id_next[k]       = id[k+1];
      end
      count_next = count - CNT_W'(1);
      if (count == CNT_W'(1)) begin
        draining_next = 1'b0;
      end
    end else if (accept) begin
      if (room) begin
        // stable descending: new job goes below all cells with profit >= its own
        for (int k = 0; k < MAX_JOBS; k++) begin
          if (CNT_W'(k) <= count) begin
            if ((CNT_W'(k) < count) && ge[k]) begin
              profit_next[k] = profit[k];
            end else if (ge_up[k]) begin
              profit_next[k]   = job.profit;
              deadline_next[k] = job.deadline;
              id_next[k]       = new_id;
            end else begin
              profit_next[k]   = profit_up[k];
              deadline_next[k] = deadline_up[k];
              id_next[k]       = id_up[k];
            end
          end
        end
        count_next = count + CNT_W'(1);
      end
      if (job.last_job) begin
        draining_next = 1'b1;
        set_size_next = room ? count + CNT_W'(1) : count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      draining <= 1'b0;
    end else begin
      count    <= count_next;
      draining <= draining_next;
    end
  end

  always_ff @(posedge clk) begin
    profit   <= profit_next;
    deadline <= deadline_next;
    id       <= id_next;
    set_size <= set_size_next;
  end

endmodule

`default_nettype wire

>>> rtl/jsds_queue.sv
// Short FIFO of ranked jobs between the front end and the slot allocator.
`default_nettype none

module jsds_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jsds_pkg::sched_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output jsds_pkg::sched_t head
);
  import jsds_pkg::*;

  sched_t             entries [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] fill;
  logic               do_push, do_pop;

  assign full       = fill == Q_CNT_W'(QUEUE_DEPTH);
  assign head_valid = fill != '0;
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

>>> rtl/jsds_back.sv
// Back end: takes the latest free slot for each ranked job, then emits filled slots in order.
`default_nettype none

module jsds_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  jsds_pkg::sched_t  head,
  output logic              pop,
  output logic              result_valid,
  output jsds_pkg::result_t result
);
  import jsds_pkg::*;

  localparam logic ST_ALLOC = 1'b0;
  localparam logic ST_EMIT  = 1'b1;

  logic                state;
  logic [MAX_JOBS-1:0] taken;
  logic [JOB_ID_W-1:0] slot_job [MAX_JOBS];
  logic [IDX_W-1:0]    idx;

  logic [MAX_JOBS-1:0] cand, above;
  logic [IDX_W-1:0]    sel;
  logic                found, none_taken, hit, is_last;

  assign pop        = (state == ST_ALLOC) && head_valid;
  assign none_taken = taken == '0;
  assign hit        = taken[idx];
  assign is_last    = above == '0;

  // free slots below the clipped deadline; the highest one wins
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int j = 0; j < MAX_JOBS; j++) begin
      cand[j]  = !taken[j] && (CNT_W'(j) < head.top);
      above[j] = taken[j] && (IDX_W'(j) > idx);
      if (cand[j]) begin
        found = 1'b1;
        sel   = IDX_W'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_ALLOC;
      taken        <= '0;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_ALLOC: begin
          if (pop) begin
            if (found) begin
              taken[sel] <= 1'b1;
            end
            if (head.last) begin
              state <= ST_EMIT;
              idx   <= '0;
            end
          end
        end
        ST_EMIT: begin
          if (none_taken) begin
            result_valid <= 1'b1;
            state        <= ST_ALLOC;
          end else begin
            idx <= idx + IDX_W'(1);
            if (hit) begin
              result_valid <= 1'b1;
              if (is_last) begin
                taken <= '0;
                state <= ST_ALLOC;
              end
            end
          end
        end
        default: state <= ST_ALLOC;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && found) begin
      slot_job[sel] <= head.job_id;
    end
    if (state == ST_EMIT) begin
      if (none_taken) begin
        result.job_id      <= '0;
        result.slot_index  <= '0;
        result.last_result <= 1'b1;
      end else begin
        result.job_id      <= slot_job[idx];
        result.slot_index  <= SLOT_W'(idx);
        result.last_result <= is_last;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/job_sequencing_deadline_scheduler.sv
// Top level: greedy job sequencing with deadlines.
//
//   channel  dir  handshake              payload
//   job      in   start & !busy          jsds_pkg::job_t
//   result   out  result_valid (1 cycle) jsds_pkg::result_t
//
// One job loads per cycle into the insertion-sort chain; busy stays low while loading.
// A job marked last_job raises busy while the chain drains its n jobs (n = jobs in the set)
// into the queue; busy also stays high while the queue is full behind a slot scan.
// The allocator takes one job per cycle while the queue holds one, then scans slots from 0
// up to the highest filled slot at one slot per cycle.
// Sync active-high reset clears count, queue and slot map; the receiver cannot stall.
`default_nettype none

module job_sequencing_deadline_scheduler (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  jsds_pkg::job_t    job,
  output logic              result_valid,
  output jsds_pkg::result_t result
);
  import jsds_pkg::*;

  logic   push, queue_full, pop, head_valid;
  sched_t push_entry, head;

  jsds_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .job        (job),
    .busy       (busy),
    .push       (push),
    .push_entry (push_entry),
    .queue_full (queue_full)
  );

  jsds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  jsds_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

>>> rtl/jsds_checker.sv
// Port-level checker for the job scheduler, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module jsds_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input jsds_pkg::job_t    job,
  input logic              result_valid,
  input jsds_pkg::result_t result
);
  import jsds_pkg::*;

  `ASSERT_IMPL(a_empty_result, result_valid && (result.job_id == '0),
               result.last_result && (result.slot_index == '0),
               "empty schedule result must be a lone last result in slot 0")
  `ASSERT_IMPL(a_id_range, result_valid, (result.job_id <= JOB_ID_W'(MAX_JOBS)),
               "job id beyond the job store")
  `ASSERT_NEXT(a_load_free, start && !busy && !job.last_job, !busy,
               "loading a job must not block the next one")
  `ASSERT_NEXT(a_last_busy, start && !busy && job.last_job, busy,
               "last job must start the drain")

endmodule

bind job_sequencing_deadline_scheduler jsds_checker u_checker (.*);

`default_nettype wire

>>> dv/jsds_checker.sv
// Checker for the job scheduler: predicts each set's schedule and compares the results.
module jsds_tb_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  jsds_pkg::job_t    job,
  input  logic              result_valid,
  input  jsds_pkg::result_t result,
  output int                fail_count,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import jsds_pkg::*;

  // jobs of the current set, kept in rank order (descending profit, stable)
  logic signed [PROFIT_W-1:0] ranked_profit   [MAX_JOBS];
  logic [DEADLINE_W-1:0]      ranked_deadline [MAX_JOBS];
  logic [JOB_ID_W-1:0]        ranked_id       [MAX_JOBS];
  int                         loaded;
  result_t                    schedule_q [$];
  int                         errs;

  assign fail_count = errs;

  function automatic void build_schedule();
    logic                slot_used [MAX_JOBS];
    logic [JOB_ID_W-1:0] slot_owner [MAX_JOBS];
    int                  top;
    int                  emitted;
    result_t             r;
    for (int s = 0; s < MAX_JOBS; s++) begin
      slot_used[s] = 1'b0;
      slot_owner[s] = '0;
    end
    for (int i = 0; i < loaded; i++) begin
      top = (ranked_deadline[i] < loaded) ? int'(ranked_deadline[i]) : loaded;
      while (top > 0) begin
        if (!slot_used[top-1]) begin
          slot_used[top-1] = 1'b1;
          slot_owner[top-1] = ranked_id[i];
          break;
        end
        top--;
      end
    end
    emitted = 0;
    for (int s = 0; s < loaded; s++) begin
      if (slot_used[s]) begin
        r.job_id      = slot_owner[s];
        r.slot_index  = SLOT_W'(s);
        r.last_result = 1'b0;
        schedule_q.push_back(r);
        emitted++;
      end
    end
    if (emitted == 0) begin
      r = '0;
      r.last_result = 1'b1;
      schedule_q.push_back(r);
    end else begin
      schedule_q[$].last_result = 1'b1;
    end
    loaded = 0;
  endfunction

  function automatic void load_job(job_t j);
    logic signed [PROFIT_W-1:0] pr;
    int                         pos;
    pr = $signed(j.profit);
    if (loaded < MAX_JOBS) begin
      pos = loaded;
      while (pos > 0 && ranked_profit[pos-1] < pr) begin
        ranked_profit[pos]   = ranked_profit[pos-1];
        ranked_deadline[pos] = ranked_deadline[pos-1];
        ranked_id[pos]       = ranked_id[pos-1];
        pos--;
      end
      ranked_profit[pos]   = pr;
      ranked_deadline[pos] = j.deadline;
      ranked_id[pos]       = JOB_ID_W'(loaded + 1);
      loaded++;
    end
    // a last mark on an overflow item still closes the set
    if (j.last_job) build_schedule();
  endfunction

  function automatic void note_failure(string what, result_t want, result_t got);
    if (errs < 10)
      $display("%0t: %s: want id %0d slot %0d last %0b, got id %0d slot %0d last %0b",
               $time, what, want.job_id, want.slot_index, want.last_result,
               got.job_id, got.slot_index, got.last_result);
    errs++;
  endfunction

  initial begin
    errs = 0;
    loaded = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      loaded = 0;
      schedule_q.delete();
    end else begin
      if (result_valid) begin
        if (schedule_q.size() == 0) begin
          note_failure("result with nothing pending", '0, result);
        end else begin
          want = schedule_q.pop_front();
          if (want.job_id !== result.job_id || want.slot_index !== result.slot_index ||
              want.last_result !== result.last_result)
            note_failure("result mismatch", want, result);
        end
      end
      if (start && !busy) load_job(job);
    end
    outstanding <= schedule_q.size();
  end

endmodule

>>> dv/tb_top.sv
// Testbench top: drives job sets into the scheduler and gives the verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import jsds_pkg::*;

  localparam int ITEMS     = 310;
  localparam int CYCLE_CAP = 200000;

  logic    clk;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  job_t    job = '0;
  logic    busy;
  logic    result_valid;
  result_t result;
  int      fails;
  int      outstanding;
  int      cycles = 0;
  int      burst_left = 0;
  int      sent = 0;

  job_sequencing_deadline_scheduler uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .job          (job),
    .result_valid (result_valid),
    .result       (result)
  );

  jsds_tb_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .job          (job),
    .result_valid (result_valid),
    .result       (result),
    .fail_count   (fails),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // one transaction; idle gaps fall between bursts of random length
  task automatic send_job(input logic [DEADLINE_W-1:0] dl, input logic [PROFIT_W-1:0] pr,
                          input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    job <= '{deadline: dl, profit: pr, last_job: last};
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic send_random_set();
    int                    n;
    int                    r;
    logic [DEADLINE_W-1:0] dl;
    logic [PROFIT_W-1:0]   pr;
    r = $urandom_range(0, 11);
    if (r == 0) n = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 6);  // overflow set
    else if (r < 3) n = $urandom_range(9, MAX_JOBS);
    else n = $urandom_range(1, 8);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 9);
      if (r == 0) dl = DEADLINE_W'($urandom);
      else if (r == 1) dl = '0;
      else dl = DEADLINE_W'($urandom_range(0, n + 1));
      r = $urandom_range(0, 9);
      if (r == 0) pr = 32'h8000_0000;
      else if (r == 1) pr = 32'h7fff_ffff;
      else if (r < 5) pr = $urandom;
      else pr = PROFIT_W'(int'($urandom_range(0, 6)) - 3);  // narrow range forces ties
      send_job(dl, pr, k == n - 1);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // single job with zero deadline: nothing scheduled
    send_job(16'd0, 32'd5, 1'b1);
    // single job, maximum deadline and profit
    send_job(16'hffff, 32'h7fff_ffff, 1'b1);
    // profit extremes, a tie, zero and clipped deadlines
    send_job(16'd1, 32'h8000_0000, 1'b0);
    send_job(16'd2, 32'h7fff_ffff, 1'b0);
    send_job(16'd2, 32'd100, 1'b0);
    send_job(16'd1, 32'd100, 1'b0);
    send_job(16'd0, 32'd500, 1'b0);
    send_job(16'hffff, 32'hffff_ffff, 1'b1);
    // equal profits keep arrival order
    send_job(16'd4, 32'd7, 1'b0);
    send_job(16'd4, 32'd7, 1'b0);
    send_job(16'd4, 32'd7, 1'b0);
    send_job(16'd4, 32'd7, 1'b1);
    // all deadlines zero
    send_job(16'd0, 32'd1, 1'b0);
    send_job(16'd0, 32'h8000_0000, 1'b0);
    send_job(16'd0, 32'h7fff_ffff, 1'b1);
    // alternating bit patterns
    send_job(16'haaaa, 32'haaaa_aaaa, 1'b0);
    send_job(16'h5555, 32'h5555_5555, 1'b0);
    send_job(16'd1, 32'h0000_0000, 1'b1);

    while (sent < ITEMS) send_random_set();
    start <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2 * MAX_JOBS + 16) @(posedge clk);
    if (fails == 0 && outstanding == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/jsds_pkg.sv
rtl/jsds_front.sv
rtl/jsds_queue.sv
rtl/jsds_back.sv
rtl/job_sequencing_deadline_scheduler.sv
rtl/jsds_checker.sv
dv/jsds_checker.sv
dv/tb_top.sv
